[src/double_ended_queue_with_search_core_macros.svh]
// Assertion macros used by the double-ended queue with search.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DEQS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed one cycle later");

`endif

[src/deqs_pkg.sv]
// Package with sizes, command and status codes, states and index helpers of the deque.
package deqs_pkg;

    // Storage depth and the widths that follow from it.
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Fixed field widths of one command beat and one result beat.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    // Full-queue count as a typed constant.
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    // Fold a sum below twice the depth back into the circular index range.
    function automatic logic [ADDR_W-1:0] f_wrap(input logic [ADDR_W:0] sum);
        logic [ADDR_W:0] folded;
        folded = sum;
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            folded = sum - (ADDR_W + 1)'(DEPTH);
        end
        return folded[ADDR_W-1:0];
    endfunction

    // Step a circular index back by one.
    function automatic logic [ADDR_W-1:0] f_dec(input logic [ADDR_W-1:0] idx);
        logic [ADDR_W-1:0] prev;
        if (idx == '0) begin
            prev = ADDR_W'(DEPTH - 1);
        end else begin
            prev = idx - ADDR_W'(1);
        end
        return prev;
    endfunction

endpackage

[src/double_ended_queue_with_search_core.sv]
// Bounded double-ended queue of 32-bit values with a front-to-back search.
//
// Channel   Direction  Handshake                  Fields
// command   in         i_start high, o_busy low   i_command, i_value
// result    out        o_done strobe, one cycle   o_found, o_count, o_status
//
// Pushes, pops and unknown commands finish in one cycle: the result beat is on the
// ports in the cycle after the command is taken, and a new command may be taken then.
// A search reads one entry per cycle through the single read port of the entry memory
// and holds o_busy high during the walk; the result comes in the cycle after the compare
// that hits, or after the compare of the last entry. Reset clears the head index and
// count at once; the entry memory needs no clearing pass.
// The receiver cannot stall: every result beat is taken in the cycle it is shown.
module double_ended_queue_with_search_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [deqs_pkg::CMD_W-1:0]            i_command,
    input  logic signed [deqs_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic                                  o_found,
    output logic [deqs_pkg::COUNT_W-1:0]          o_count,
    output logic [deqs_pkg::STATUS_W-1:0]         o_status
);
    import deqs_pkg::*;

    // Control state.
    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_head,  n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_done,  n_done;

    // Payload state.
    logic [CNT_W-1:0]    r_idx,    n_idx;
    logic [VALUE_W-1:0]  r_key,    n_key;
    logic                r_found,  n_found;
    logic [STATUS_W-1:0] r_status, n_status;

    // Entry memory with a registered read port.
    logic [VALUE_W-1:0]  r_mem [DEPTH];
    logic [VALUE_W-1:0]  r_rd_data;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [ADDR_W-1:0]   w_raddr;
    logic [ADDR_W-1:0]   w_front_slot;
    logic [ADDR_W-1:0]   w_back_slot;

    assign w_front_slot = f_dec(r_head);
    assign w_back_slot  = f_wrap((ADDR_W + 1)'(r_head) + (ADDR_W + 1)'(r_count));

    // Next state, memory access and result for each command.
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_done   = 1'b0;
        n_idx    = r_idx;
        n_key    = r_key;
        n_found  = r_found;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_head;
        w_raddr  = r_head;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_done   = 1'b1;
                    n_found  = 1'b0;
                    n_status = STS_OK;
                    n_key    = i_value;
                    n_idx    = CNT_W'(1);
                    case (i_command)
                        CMD_PUSH_FRONT: begin
                            if (r_count == CNT_FULL) begin
                                n_status = STS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_front_slot;
                                n_head  = w_front_slot;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_PUSH_BACK: begin
                            if (r_count == CNT_FULL) begin
                                n_status = STS_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_back_slot;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_head  = f_wrap((ADDR_W + 1)'(r_head) + (ADDR_W + 1)'(1));
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_status = STS_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        CMD_SEARCH: begin
                            // The front entry is read at this edge; on a non-empty queue results wait for the walk.
                            if (r_count != '0) begin
                                n_done  = 1'b0;
                                n_state = S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                // Compare the entry read last cycle and fetch the one after it.
                w_raddr = f_wrap((ADDR_W + 1)'(r_head) + (ADDR_W + 1)'(r_idx));
                if (r_rd_data == r_key) begin
                    n_done  = 1'b1;
                    n_found = 1'b1;
                    n_state = S_IDLE;
                end else if (r_idx == r_count) begin
                    n_done  = 1'b1;
                    n_found = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_found  <= n_found;
        r_status <= n_status;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= n_key;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // Result ports.
    assign o_busy   = (r_state == S_SEARCH);
    assign o_done   = r_done;
    assign o_found  = r_found;
    assign o_count  = COUNT_W'(r_count);
    assign o_status = r_status;

    // Checks on the controller.
`include "double_ended_queue_with_search_core_macros.svh"

    `DEQS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `DEQS_ASSERT_NEXT(a_short_cmd_done, i_clk, i_rst_n, i_start && !o_busy && i_command != CMD_SEARCH, o_done && !o_busy)
    `DEQS_ASSERT_SAME(a_walk_in_range, i_clk, i_rst_n, r_state == S_SEARCH, r_count != '0 && r_idx <= r_count && !o_done)
    `DEQS_ASSERT_SAME(a_found_is_ok, i_clk, i_rst_n, o_done && o_found, o_status == STS_OK)

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the double-ended queue with search: directed and random commands.
module tb_top;
    import deqs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = DEPTH + 8;
    localparam int ERR_PRINT_MAX = 100;

    // Command codes above search are no-ops in the block.
    localparam logic [CMD_W-1:0] CMD_NOP_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_NOP_MID   = 3'd6;
    localparam logic [CMD_W-1:0] CMD_NOP_LAST  = 3'd7;

    // Value patterns at the edges of the signed range, at zero and at minus one.
    localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] VAL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                found;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_deque_result;

    logic                        i_clk;
    logic                        i_rst_n   = 1'b0;
    logic                        i_start   = 1'b0;
    logic [CMD_W-1:0]            i_command = CMD_NOP_FIRST;
    logic signed [VALUE_W-1:0]   i_value   = '0;
    logic                        o_busy;
    logic                        o_done;
    logic                        o_found;
    logic [COUNT_W-1:0]          o_count;
    logic [STATUS_W-1:0]         o_status;

    // Shadow copy of the queue contents used for prediction.
    logic [VALUE_W-1:0] entry_copy [DEPTH];
    int                 model_head  = 0;
    int                 model_count = 0;

    t_deque_result      pending_results [$];
    t_deque_result      want;
    int                 cmds_taken   = 0;
    int                 stall_cycles = 0;
    int                 n_errors     = 0;
    int                 no_gap_pct   = 50;

    double_ended_queue_with_search_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_command),
        .i_value   (i_value),
        .o_busy    (o_busy),
        .o_done    (o_done),
        .o_found   (o_found),
        .o_count   (o_count),
        .o_status  (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Circular store slot that lies a given distance behind the front.
    function automatic int slot_of(input int offset);
        return (model_head + offset) % DEPTH;
    endfunction

    // Apply one command to the shadow queue and return the result it must produce.
    function automatic t_deque_result apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [VALUE_W-1:0] val);
        t_deque_result res;
        int            i;
        res = '0;
        res.status = STS_OK;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (model_count >= DEPTH) begin
                    res.status = STS_FULL;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    model_head = (model_head + DEPTH - 1) % DEPTH;
                    entry_copy[model_head] = val;
                    model_count++;
                end else begin
                    entry_copy[slot_of(model_count)] = val;
                    model_count++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (model_count == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        model_head = slot_of(1);
                    end
                    model_count--;
                end
            end
            CMD_SEARCH: begin
                for (i = 0; i < model_count; i++) begin
                    if (entry_copy[slot_of(i)] == val) begin
                        res.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(model_count);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        n_errors++;
        if (n_errors <= ERR_PRINT_MAX) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
        end
    endtask

    // Check each result beat, then record any command beat taken at this edge.
    // The watchdog runs here too since both handshakes are visible at once.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 0, 1);
                end else begin
                    want = pending_results.pop_front();
                    if (o_found !== want.found) begin
                        report_mismatch("found", want.found, o_found);
                    end
                    if (o_count !== want.count) begin
                        report_mismatch("count", want.count, o_count);
                    end
                    if (o_status !== want.status) begin
                        report_mismatch("status", want.status, o_status);
                    end
                end
            end
            if (i_start && !o_busy) begin
                pending_results.push_back(apply_command(i_command, i_value));
                cmds_taken++;
            end
            if ((i_start && !o_busy) || o_done) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL double_ended_queue_with_search_core");
                $finish;
            end
        end
    end

    // Random gap after a beat: mostly none or short, now and then long.
    task automatic idle_gap();
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) >= no_gap_pct) begin
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        end
        if (gap != 0) begin
            i_start   <= 1'b0;
            i_command <= CMD_W'($urandom);
            i_value   <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Present one command beat and return once the block has taken it and any idle gap is over.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        int target;
        target = cmds_taken + 1;
        i_start   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        wait (cmds_taken == target);
        idle_gap();
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mix of edge patterns, small values that repeat, and full random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return VAL_MIN;
        if (r < 8) return VAL_MAX;
        if (r < 11) return VAL_ZERO;
        if (r < 15) return VAL_ONES;
        if (r < 35) return VALUE_W'($urandom_range(0, 7));
        return $urandom;
    endfunction

    // Searches mostly look for something stored, at any depth in the queue.
    function automatic logic [VALUE_W-1:0] pick_search_value();
        if (model_count != 0 && $urandom_range(0, 99) < 60) begin
            return entry_copy[slot_of($urandom_range(0, model_count - 1))];
        end
        return pick_value();
    endfunction

    task automatic send_random_cmd(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            send_cmd(CMD_W'($urandom_range(CMD_NOP_FIRST, CMD_NOP_LAST)), pick_value());
        end else if (r < 25) begin
            send_cmd(CMD_SEARCH, pick_search_value());
        end else if ($urandom_range(0, 99) < push_pct) begin
            send_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end else begin
            send_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
        end
    endtask

    // Pops, searches and no-ops on an empty queue.
    task automatic test_empty_queue();
        send_cmd(CMD_POP_FRONT, VAL_ONES);
        send_cmd(CMD_POP_BACK, VAL_MIN);
        send_cmd(CMD_SEARCH, VAL_ZERO);
        send_cmd(CMD_SEARCH, VAL_MIN);
        send_cmd(CMD_NOP_FIRST, VAL_MAX);
        send_cmd(CMD_NOP_MID, VAL_ZERO);
        send_cmd(CMD_NOP_LAST, VAL_ONES);
    endtask

    // Extreme values pushed at both ends, found at each position, then popped out.
    task automatic test_value_extremes();
        send_cmd(CMD_PUSH_BACK, VAL_MAX);
        send_cmd(CMD_PUSH_FRONT, VAL_MIN);
        send_cmd(CMD_PUSH_BACK, VAL_ZERO);
        send_cmd(CMD_PUSH_FRONT, VAL_ONES);
        send_cmd(CMD_SEARCH, VAL_ONES);
        send_cmd(CMD_SEARCH, VAL_MIN);
        send_cmd(CMD_SEARCH, VAL_MAX);
        send_cmd(CMD_SEARCH, VAL_ZERO);
        send_cmd(CMD_SEARCH, 32'h0000_0001);
        send_cmd(CMD_NOP_MID, VAL_MIN);
        send_cmd(CMD_POP_FRONT, VAL_ZERO);
        send_cmd(CMD_POP_BACK, VAL_ONES);
        send_cmd(CMD_SEARCH, VAL_ZERO);
        send_cmd(CMD_POP_BACK, VAL_ZERO);
        send_cmd(CMD_POP_FRONT, VAL_ZERO);
        send_cmd(CMD_POP_FRONT, VAL_ZERO);
    endtask

    // Fill to capacity, push into the full queue, search it, then empty it again.
    task automatic test_fill_and_drain();
        while (model_count < DEPTH) begin
            send_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        end
        send_cmd(CMD_PUSH_FRONT, pick_value());
        send_cmd(CMD_PUSH_BACK, pick_value());
        send_cmd(CMD_SEARCH, entry_copy[slot_of(DEPTH - 1)]);
        send_cmd(CMD_SEARCH, $urandom);
        while (model_count > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_cmd(CMD_SEARCH, pick_search_value());
            end else begin
                send_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
            end
        end
        send_cmd(CMD_POP_BACK, pick_value());
    endtask

    // Phases that lean toward filling or emptying, some of them without idle cycles.
    task automatic test_random_mix();
        int push_bias [6] = '{80, 20, 55, 90, 10, 45};
        int p;
        int k;
        for (p = 0; p < 12; p++) begin
            no_gap_pct = (p % 4 == 3) ? 100 : 50;
            for (k = 0; k < 50; k++) begin
                send_random_cmd(push_bias[p % 6]);
            end
        end
        no_gap_pct = 50;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_queue();
        test_value_extremes();
        // Hold the sender off until every result so far has come back.
        wait_drained();
        test_fill_and_drain();
        test_random_mix();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("PASS double_ended_queue_with_search_core");
        end else begin
            $display("FAIL double_ended_queue_with_search_core");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/deqs_pkg.sv
src/double_ended_queue_with_search_core.sv
dv/tb_top.sv
